// File: src/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Request codes, status codes and fixed field widths of the bounded list.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FIND       = 3'd4;
    localparam logic [REQ_W-1:0] REQ_ERASE      = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// File: src/bounded_list_with_search_erase.sv
// ----------------------------------------------------------------------------
// bounded_list_with_search_erase
// Ordered list of up to DEPTH values in a circular store with search/erase.
// Sequence: a taken request runs S_EXEC, then S_RD_FRONT, S_RD_BACK and
// S_RD_LAST (reads skipped when the list ends up empty) and S_DONE; find and
// erase walk the list in S_SCAN first; an erase hit then shifts in S_SHIFT.
// One request at a time: in_stall stays high until the result is loaded, so a
// new transfer is taken the cycle after that, later while out_stall holds it.
// Reset clears head, count and handshake state; store contents stay undefined.
// ----------------------------------------------------------------------------
module bounded_list_with_search_erase
    import bls_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [VALUE_W-1:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic                hit,
    output logic [VALUE_W-1:0]  front_value,
    output logic [VALUE_W-1:0]  back_value,
    output logic [COUNT_W-1:0]  count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef logic [AW-1:0]         addr_t;
    typedef logic [CW-1:0]         cnt_t;
    typedef logic [DATA_WIDTH-1:0] data_t;

    localparam addr_t LAST_SLOT = AW'(DEPTH - 1);
    localparam cnt_t  FULL_CNT  = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT,
        S_RD_FRONT,
        S_RD_BACK,
        S_RD_LAST,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [REQ_W-1:0]     kind_reg, kind_next;
    data_t                val_reg, val_next;
    addr_t                head_reg, head_next;
    cnt_t                 count_reg, count_next;
    addr_t                rptr_reg, rptr_next;
    addr_t                lptr_reg, lptr_next;
    cnt_t                 ridx_reg, ridx_next;
    cnt_t                 lidx_reg, lidx_next;
    logic                 pend_reg, pend_next;
    logic                 hit_reg, hit_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    data_t                front_reg, front_next;
    data_t                back_reg, back_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic                 out_hit_reg, out_hit_next;
    logic [VALUE_W-1:0]   out_front_reg, out_front_next;
    logic [VALUE_W-1:0]   out_back_reg, out_back_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;

    logic  mem_we;
    addr_t mem_waddr;
    data_t mem_wdata;
    addr_t mem_raddr;
    data_t mem_rdata;

    function automatic addr_t slot_inc(addr_t a);
        return (a == LAST_SLOT) ? '0 : a + AW'(1);
    endfunction

    // head plus offset, wrapped into the store
    function automatic addr_t wrap_add(addr_t h, cnt_t n);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(n);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    bls_mem
    #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        val_next        = val_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        rptr_next       = rptr_reg;
        lptr_next       = lptr_reg;
        ridx_next       = ridx_reg;
        lidx_next       = lidx_reg;
        pend_next       = pend_reg;
        hit_next        = hit_reg;
        status_next     = status_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_hit_next    = out_hit_reg;
        out_front_next  = out_front_reg;
        out_back_next   = out_back_reg;
        out_count_next  = out_count_reg;

        mem_we    = 1'b0;
        mem_waddr = head_reg;
        mem_wdata = val_reg;
        mem_raddr = rptr_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next   = req_type;
                    val_next    = DATA_WIDTH'(value);
                    hit_next    = 1'b0;
                    status_next = ST_OK;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_RD_FRONT;
                case (kind_reg)
                    REQ_PUSH_BACK:
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = wrap_add(head_reg, count_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    REQ_PUSH_FRONT:
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            head_next  = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);
                            mem_we     = 1'b1;
                            mem_waddr  = head_next;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    REQ_POP_FRONT:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            head_next  = slot_inc(head_reg);
                            count_next = count_reg - CW'(1);
                        end
                    end
                    REQ_POP_BACK:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    REQ_FIND, REQ_ERASE:
                    begin
                        if (count_reg != '0)
                        begin
                            rptr_next  = head_reg;
                            ridx_next  = '0;
                            pend_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = S_RD_FRONT;
                    end
                endcase
            end

            // issue one read a cycle, compare the entry read the cycle before
            S_SCAN:
            begin
                mem_raddr = rptr_reg;
                if (pend_reg && (mem_rdata == val_reg))
                begin
                    hit_next = 1'b1;
                    if (kind_reg == REQ_ERASE)
                    begin
                        rptr_next  = lptr_reg;
                        ridx_next  = lidx_reg;
                        pend_next  = 1'b0;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_RD_FRONT;
                    end
                end
                else if (ridx_reg == count_reg)
                begin
                    state_next = S_RD_FRONT;
                end
                else
                begin
                    lptr_next = rptr_reg;
                    lidx_next = ridx_reg;
                    rptr_next = slot_inc(rptr_reg);
                    ridx_next = ridx_reg + CW'(1);
                    pend_next = 1'b1;
                end
            end

            // move each later entry down one slot to close the gap
            S_SHIFT:
            begin
                mem_raddr = slot_inc(rptr_reg);
                mem_waddr = lptr_reg;
                mem_wdata = mem_rdata;
                mem_we    = pend_reg;
                if (((CW+1)'(ridx_reg) + (CW+1)'(1)) < (CW+1)'(count_reg))
                begin
                    lptr_next = rptr_reg;
                    rptr_next = slot_inc(rptr_reg);
                    ridx_next = ridx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_RD_FRONT;
                    end
                end
            end

            S_RD_FRONT:
            begin
                if (count_reg == '0)
                begin
                    front_next = '0;
                    back_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr  = head_reg;
                    state_next = S_RD_BACK;
                end
            end

            S_RD_BACK:
            begin
                mem_raddr  = wrap_add(head_reg, count_reg - CW'(1));
                front_next = mem_rdata;
                state_next = S_RD_LAST;
            end

            S_RD_LAST:
            begin
                back_next  = mem_rdata;
                state_next = S_DONE;
            end

            // hold until the output register is free
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_hit_next    = hit_reg;
                    out_front_next  = VALUE_W'(front_reg);
                    out_back_next   = VALUE_W'(back_reg);
                    out_count_next  = COUNT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= '0;
            val_reg        <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            rptr_reg       <= '0;
            lptr_reg       <= '0;
            ridx_reg       <= '0;
            lidx_reg       <= '0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            status_reg     <= ST_OK;
            front_reg      <= '0;
            back_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_hit_reg    <= 1'b0;
            out_front_reg  <= '0;
            out_back_reg   <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            val_reg        <= val_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            rptr_reg       <= rptr_next;
            lptr_reg       <= lptr_next;
            ridx_reg       <= ridx_next;
            lidx_reg       <= lidx_next;
            pend_reg       <= pend_next;
            hit_reg        <= hit_next;
            status_reg     <= status_next;
            front_reg      <= front_next;
            back_reg       <= back_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_hit_reg    <= out_hit_next;
            out_front_reg  <= out_front_next;
            out_back_reg   <= out_back_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign hit         = out_hit_reg;
    assign front_value = out_front_reg;
    assign back_value  = out_back_reg;
    assign count       = out_count_reg;

endmodule

// File: src/bls_mem.sv
// ----------------------------------------------------------------------------
// bls_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bls_mem
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_WIDTH-1:0]    wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_WIDTH-1:0]    rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
